[hdl/owm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package owm_pkg;

    localparam int TICK_W   = 12;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_RST_HIGH = 3'd3,
        PH_INIT     = 3'd4,
        PH_WR_DATA  = 3'd5,
        PH_RD_WAIT  = 3'd6,
        PH_RD_SLOT  = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } command_t;

    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd4;

    localparam logic [11:0] RESET_LOW_DEFAULT     = 12'd600;
    localparam logic [9:0]  PRESENCE_WAIT_DEFAULT = 10'd60;
    localparam logic [5:0]  INIT_LOW_DEFAULT      = 6'd2;
    localparam logic [5:0]  READ_SAMPLE_DEFAULT   = 6'd2;
    localparam logic [9:0]  SLOT_DEFAULT          = 10'd60;

    typedef struct packed {
        logic [11:0] reset_low_ticks;
        logic [9:0]  presence_wait_ticks;
        logic [5:0]  init_low_ticks;
        logic [5:0]  read_sample_ticks;
        logic [9:0]  slot_ticks;
    } owm_timing_t;

    typedef struct packed {
        phase_t            phase;
        logic [TICK_W-1:0] tick_count;
        logic [2:0]        bit_index;
        logic [7:0]        out_shift;
        logic [7:0]        in_shift;
        logic              presence_flag;
        logic [1:0]        op_kind;
    } owm_state_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence_level;
        logic [7:0] read_byte;
    } owm_result_t;

endpackage

`default_nettype wire

[hdl/owm_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module owm_step
    import owm_pkg::*;
(
    input  owm_state_t  state,
    input  owm_timing_t timing,
    input  logic [1:0]  command,
    input  logic [7:0]  write_byte,
    input  logic        line_level,
    output owm_state_t  state_next,
    output owm_result_t result
);

    owm_state_t        s;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] phase_len;
    logic              phase_end;
    logic              drive;
    logic              done;

    always_comb
    begin
        s = state;
        if ((state.phase == PH_IDLE) && (command != CMD_NONE))
        begin
            s.op_kind    = command;
            s.tick_count = '0;
            s.bit_index  = '0;
            if (command == CMD_RESET)
            begin
                s.phase = PH_RST_LOW;
            end
            else
            begin
                s.phase     = PH_INIT;
                s.out_shift = (command == CMD_WRITE) ? write_byte : 8'h00;
            end
        end

        case (s.phase)
            PH_RST_LOW:  phase_len = timing.reset_low_ticks;
            PH_RST_WAIT: phase_len = {2'b00, timing.presence_wait_ticks};
            PH_INIT:     phase_len = {6'd0, timing.init_low_ticks};
            PH_RD_WAIT:  phase_len = {6'd0, timing.read_sample_ticks};
            default:     phase_len = {2'b00, timing.slot_ticks};
        endcase

        tick_inc  = s.tick_count + 12'd1;
        phase_end = (tick_inc >= phase_len);
        drive     = 1'b0;
        done      = 1'b0;

        case (s.phase)
            PH_RST_LOW:
            begin
                drive        = 1'b1;
                s.tick_count = phase_end ? '0 : tick_inc;
                if (phase_end)
                begin
                    s.phase = PH_RST_WAIT;
                end
            end
            PH_RST_WAIT:
            begin
                s.tick_count = phase_end ? '0 : tick_inc;
                if (phase_end)
                begin
                    s.presence_flag = line_level;
                    s.phase         = PH_RST_HIGH;
                end
            end
            PH_RST_HIGH:
            begin
                if (line_level)
                begin
                    s.tick_count = '0;
                    s.phase      = PH_IDLE;
                    done         = 1'b1;
                end
            end
            PH_INIT:
            begin
                drive        = 1'b1;
                s.tick_count = phase_end ? '0 : tick_inc;
                if (phase_end)
                begin
                    s.phase = (s.op_kind == CMD_WRITE) ? PH_WR_DATA : PH_RD_WAIT;
                end
            end
            PH_RD_WAIT:
            begin
                s.tick_count = phase_end ? '0 : tick_inc;
                if (phase_end)
                begin
                    s.in_shift[s.bit_index] = line_level;
                    s.phase                 = PH_RD_SLOT;
                end
            end
            PH_WR_DATA, PH_RD_SLOT:
            begin
                if (s.phase == PH_WR_DATA)
                begin
                    drive = ~s.out_shift[0];
                end
                s.tick_count = phase_end ? '0 : tick_inc;
                if (phase_end)
                begin
                    if (s.bit_index == 3'd7)
                    begin
                        s.bit_index = '0;
                        s.phase     = PH_IDLE;
                        done        = 1'b1;
                    end
                    else
                    begin
                        s.bit_index = s.bit_index + 3'd1;
                        s.out_shift = {1'b0, s.out_shift[7:1]};
                        s.phase     = PH_INIT;
                    end
                end
            end
            default:
            begin
            end
        endcase

        state_next            = s;
        result.drive_low      = drive;
        result.busy           = (s.phase != PH_IDLE);
        result.done           = done;
        result.presence_level = s.presence_flag;
        result.read_byte      = s.in_shift;
    end

endmodule

`default_nettype wire

[hdl/one_wire_bus_master_core.sv]
// One tick is taken per transaction; its result is registered and appears in the next cycle.
// Throughput is one tick per cycle unless stalled: the bus state machine advances once per
// accepted tick through a single combinational step between the state and result
// registers. A new tick is taken while the result register is empty or being drained.
// Reset clears the bus state (idle, presence flag high) and loads the default timing.
`timescale 1ns / 1ps
`default_nettype none

module one_wire_bus_master_core
    import owm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           command,
    input  wire logic [7:0]           write_byte,
    input  wire logic                 line_level,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      drive_low,
    output logic                      busy_res,
    output logic                      done_res,
    output logic                      presence_level,
    output logic [7:0]                read_byte
);

    owm_timing_t timing_reg;
    owm_state_t  state_reg;
    owm_state_t  state_next;
    owm_result_t result_next;
    owm_result_t result_reg;
    logic        out_valid_reg;
    logic        in_take;

    assign in_ready = ~out_valid_reg | out_ready;
    assign in_take  = in_valid & in_ready;

    owm_step u_step (
        .state      (state_reg),
        .timing     (timing_reg),
        .command    (command),
        .write_byte (write_byte),
        .line_level (line_level),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.reset_low_ticks     <= RESET_LOW_DEFAULT;
            timing_reg.presence_wait_ticks <= PRESENCE_WAIT_DEFAULT;
            timing_reg.init_low_ticks      <= INIT_LOW_DEFAULT;
            timing_reg.read_sample_ticks   <= READ_SAMPLE_DEFAULT;
            timing_reg.slot_ticks          <= SLOT_DEFAULT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RESET_LOW:     timing_reg.reset_low_ticks     <= cfg_data;
                REG_PRESENCE_WAIT: timing_reg.presence_wait_ticks <= cfg_data[9:0];
                REG_INIT_LOW:      timing_reg.init_low_ticks      <= cfg_data[5:0];
                REG_READ_SAMPLE:   timing_reg.read_sample_ticks   <= cfg_data[5:0];
                REG_SLOT:          timing_reg.slot_ticks          <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_IDLE;
            state_reg.tick_count    <= '0;
            state_reg.bit_index     <= '0;
            state_reg.out_shift     <= '0;
            state_reg.in_shift      <= '0;
            state_reg.presence_flag <= 1'b1;
            state_reg.op_kind       <= '0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                state_reg <= state_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_low      = result_reg.drive_low;
    assign busy_res       = result_reg.busy;
    assign done_res       = result_reg.done;
    assign presence_level = result_reg.presence_level;
    assign read_byte      = result_reg.read_byte;

endmodule

`default_nettype wire
